// File: design/slp_pkg.sv
// Shared package for the slot pool oldest-select block.
// Holds action codes, status codes, word types and control structs.
// No dependencies.
package slp_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int TIME_BITS_DEF  = 32;

    localparam logic [2:0] ACT_ALLOC = 3'd0;
    localparam logic [2:0] ACT_FREE  = 3'd1;
    localparam logic [2:0] ACT_SET   = 3'd2;
    localparam logic [2:0] ACT_TAKE  = 3'd3;
    localparam logic [2:0] ACT_FIND  = 3'd4;
    localparam logic [2:0] ACT_WSEQ  = 3'd5;
    localparam logic [2:0] ACT_CLEAR = 3'd6;

    localparam logic [2:0] STATUS_FREE    = 3'd0;
    localparam logic [2:0] STATUS_PENDING = 3'd1;
    localparam logic [3:0] STATUS_MAX     = 4'd7;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  slot_index;
        logic [3:0]  target_state;
        logic [7:0]  seq_number;
        logic        skip_valid;
        logic [2:0]  skip_slot;
        logic [31:0] now_tick;
    } t_in_word;

    typedef struct packed {
        logic       found;
        logic [2:0] result_slot;
        logic       accepted;
    } t_out_word;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic inval_one;
        logic inval_all;
    } t_store_op;

    typedef struct packed {
        logic hit;
        logic take;
    } t_cmp_res;

endpackage

// File: design/slp_stream_if.sv
// Valid/ready stream interface carrying one word of type T.
// Depends on nothing; payload type is set by the instantiating scope.
interface slp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/slp_store.sv
// Slot storage: one-port memory of packed slot words plus per-slot valid bits.
// Invalid slots read as all zero. Depends on slp_pkg.
module slp_store #(
    parameter int SLOT_COUNT = 8,
    parameter int TIME_BITS  = 32,
    parameter int IW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    parameter int WW         = 3 + TIME_BITS + 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  slp_pkg::t_store_op  i_op,
    input  logic [IW-1:0]       i_addr,
    input  logic [WW-1:0]       i_wr_word,
    output logic [WW-1:0]       o_rd_word
);
    import slp_pkg::*;

    logic [WW-1:0]         r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [WW-1:0]         r_q;
    logic                  r_q_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_op.inval_all) begin
            r_valid <= '0;
        end else if (i_op.inval_one) begin
            r_valid[i_addr] <= 1'b0;
        end else if (i_op.wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.wr_en) begin
            r_mem[i_addr] <= i_wr_word;
        end
        if (i_op.rd_en) begin
            r_q     <= r_mem[i_addr];
            r_q_vld <= r_valid[i_addr];
        end
    end

    assign o_rd_word = r_q_vld ? r_q : '0;

endmodule

// File: design/slp_cmp.sv
// Shared compare unit: judges one slot word against the current search.
// Used for alloc, take oldest and find seq scans. Depends on slp_pkg.
module slp_cmp #(
    parameter int SLOT_COUNT = 8,
    parameter int TIME_BITS  = 32,
    parameter int IW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    parameter int WW         = 3 + TIME_BITS + 8
) (
    input  slp_pkg::t_in_word   i_cmd,
    input  logic [IW-1:0]       i_idx,
    input  logic [WW-1:0]       i_word,
    input  logic                i_have,
    input  logic [TIME_BITS-1:0] i_best_time,
    output slp_pkg::t_cmp_res   o_res
);
    import slp_pkg::*;

    logic [2:0]           status;
    logic [TIME_BITS-1:0] stamp;
    logic [7:0]           seq;
    logic                 skipped;

    assign status  = i_word[WW-1 -: 3];
    assign stamp   = i_word[TIME_BITS+7:8];
    assign seq     = i_word[7:0];
    assign skipped = i_cmd.skip_valid && (7'(i_idx) == 7'(i_cmd.skip_slot));

    always_comb begin
        o_res = '0;
        case (i_cmd.action)
            ACT_ALLOC: begin
                o_res.hit  = (status == STATUS_FREE);
                o_res.take = o_res.hit && !i_have;
            end
            ACT_TAKE: begin
                o_res.hit  = ({1'b0, status} == i_cmd.target_state);
                o_res.take = o_res.hit && (!i_have || (stamp < i_best_time));
            end
            ACT_FIND: begin
                o_res.hit  = (status != STATUS_FREE) && (seq == i_cmd.seq_number) && !skipped;
                o_res.take = o_res.hit && !i_have;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// File: design/slot_pool_oldest_select.sv
// Slot pool with oldest-first selection: top level, sequencer and result register.
// Uses slp_pkg, slp_stream_if, slp_store and slp_cmp.
//
// One word in gives one word out. Alloc, take oldest and find seq scan the pool
// through the single read port of the slot memory, one slot per cycle. Set
// status and write seq do one read and one write; free and clear all do no read;
// an unused action code goes straight to the result. Input ready is high only
// while the sequencer is idle; the result sits in an output register so a
// stalled result does not hold the scan of the word after it. Reset clears
// every slot at once through valid bits.
module slot_pool_oldest_select #(
    parameter int SLOT_COUNT = slp_pkg::SLOT_COUNT_DEF,
    parameter int TIME_BITS  = slp_pkg::TIME_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slp_stream_if.sink    i_item,
    slp_stream_if.source  o_result
);
    import slp_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int WW = 3 + TIME_BITS + 8;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]     r_state, n_state;
    logic           r_out_valid, n_out_valid;
    logic           r_pipe_v, n_pipe_v;
    t_in_word       r_cmd, n_cmd;
    t_out_word      r_res, n_res;
    t_out_word      r_out, n_out;
    logic [IW-1:0]  r_addr, n_addr;
    logic [IW-1:0]  r_pipe_idx, n_pipe_idx;
    logic [IW-1:0]  r_best_idx, n_best_idx;
    logic [WW-1:0]  r_best_word, n_best_word;
    logic           r_have, n_have;

    t_store_op      op;
    logic [IW-1:0]  addr;
    logic [WW-1:0]  wr_word;
    logic [WW-1:0]  rd_word;
    t_cmp_res       cmp;
    logic           in_idx_ok;
    logic           out_free;

    slp_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS),
        .IW         (IW),
        .WW         (WW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_addr    (addr),
        .i_wr_word (wr_word),
        .o_rd_word (rd_word)
    );

    slp_cmp #(
        .SLOT_COUNT (SLOT_COUNT),
        .TIME_BITS  (TIME_BITS),
        .IW         (IW),
        .WW         (WW)
    ) u_cmp (
        .i_cmd       (r_cmd),
        .i_idx       (r_pipe_idx),
        .i_word      (rd_word),
        .i_have      (r_have),
        .i_best_time (r_best_word[TIME_BITS+7:8]),
        .o_res       (cmp)
    );

    assign in_idx_ok      = 7'(i_item.data.slot_index) < 7'(SLOT_COUNT);
    assign out_free       = !r_out_valid || o_result.ready;
    assign i_item.ready   = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_res       = r_res;
        n_addr      = r_addr;
        n_pipe_v    = 1'b0;
        n_pipe_idx  = r_pipe_idx;
        n_best_idx  = r_best_idx;
        n_best_word = r_best_word;
        n_have      = r_have;
        op          = '0;
        addr        = r_addr;
        wr_word     = rd_word;

        case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_cmd            = i_item.data;
                    n_have           = 1'b0;
                    n_addr           = IW'(i_item.data.slot_index);
                    n_res            = '0;
                    n_res.accepted   = 1'b1;
                    n_state          = S_DONE;
                    case (i_item.data.action)
                        ACT_ALLOC, ACT_TAKE, ACT_FIND: begin
                            n_addr  = '0;
                            n_state = S_SCAN;
                        end
                        ACT_SET: begin
                            if (i_item.data.target_state > STATUS_MAX) begin
                                n_res.accepted = 1'b0;
                            end else if (in_idx_ok) begin
                                n_state = S_READ;
                            end
                        end
                        ACT_WSEQ: begin
                            if (in_idx_ok) begin
                                n_state = S_READ;
                            end
                        end
                        ACT_FREE: begin
                            if (in_idx_ok) begin
                                n_state = S_WB;
                            end
                        end
                        ACT_CLEAR: begin
                            n_state = S_WB;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                op.rd_en   = 1'b1;
                n_pipe_v   = 1'b1;
                n_pipe_idx = r_addr;
                if (r_addr == IW'(SLOT_COUNT - 1)) begin
                    n_state = S_LAST;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_LAST: begin
                n_state = S_WB;
            end
            S_READ: begin
                op.rd_en = 1'b1;
                n_state  = S_WB;
            end
            S_WB: begin
                n_state        = S_DONE;
                n_res          = '0;
                n_res.accepted = 1'b1;
                case (r_cmd.action)
                    ACT_ALLOC: begin
                        if (r_have) begin
                            op.wr_en          = 1'b1;
                            addr              = r_best_idx;
                            wr_word           = {STATUS_PENDING, r_best_word[WW-4:0]};
                            n_res.found       = 1'b1;
                            n_res.result_slot = 3'(r_best_idx);
                        end
                    end
                    ACT_TAKE: begin
                        if (r_have) begin
                            op.wr_en          = 1'b1;
                            addr              = r_best_idx;
                            wr_word           = {r_best_word[WW-1 -: 3],
                                                 TIME_BITS'(r_cmd.now_tick),
                                                 r_best_word[7:0]};
                            n_res.found       = 1'b1;
                            n_res.result_slot = 3'(r_best_idx);
                        end
                    end
                    ACT_FIND: begin
                        if (r_have) begin
                            n_res.found       = 1'b1;
                            n_res.result_slot = 3'(r_best_idx);
                        end
                    end
                    ACT_SET: begin
                        op.wr_en          = 1'b1;
                        wr_word           = {r_cmd.target_state[2:0], rd_word[WW-4:0]};
                        n_res.found       = 1'b1;
                        n_res.result_slot = 3'(r_addr);
                    end
                    ACT_WSEQ: begin
                        op.wr_en          = 1'b1;
                        wr_word           = {rd_word[WW-1:8], r_cmd.seq_number};
                        n_res.found       = 1'b1;
                        n_res.result_slot = 3'(r_addr);
                    end
                    ACT_FREE: begin
                        op.inval_one      = 1'b1;
                        n_res.found       = 1'b1;
                        n_res.result_slot = 3'(r_addr);
                    end
                    ACT_CLEAR: begin
                        op.inval_all = 1'b1;
                        n_res.found  = 1'b1;
                    end
                    default: begin
                        n_res.found = 1'b0;
                    end
                endcase
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_pipe_v && cmp.take) begin
            n_have      = 1'b1;
            n_best_idx  = r_pipe_idx;
            n_best_word = rd_word;
        end

        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;
        if ((r_state == S_DONE) && out_free) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pipe_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pipe_v    <= n_pipe_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_res       <= n_res;
        r_out       <= n_out;
        r_addr      <= n_addr;
        r_pipe_idx  <= n_pipe_idx;
        r_best_idx  <= n_best_idx;
        r_best_word <= n_best_word;
        r_have      <= n_have;
    end

endmodule
